[design/ple_pkg.sv]
`timescale 1ns / 1ps

package ple_pkg;

  typedef logic signed [31:0] data_t;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [8:0] position;
    data_t      value;
  } in_item_t;

  typedef struct packed {
    data_t      read_value;
    logic [1:0] status;
    logic [8:0] length;
  } out_item_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

[design/positional_list_engine_unit.sv]
`timescale 1ns / 1ps

// Positional list engine: an ordered list of up to DEPTH signed 32-bit values,
// numbered from position 1, held in a chain of cells with one entry per cell.
// An item is accepted on a clock edge where start is high and busy is low, and
// every item returns exactly one result on out_item, marked by out_strobe for a
// single cycle. The receiver cannot stall, so the result must be captured in
// that cycle. Inserts, deletes and any refused item never raise busy: the
// cells at and behind the operation point shift on the accepting edge (a
// refused item moves none), the result appears in the next cycle and busy
// stays low, so these items can be issued every cycle. A legal read raises
// busy while the registered radix-4 OR tree brings the selected cell to the
// output; its result is strobed as busy falls. Refused items
// (bad position, unknown opcode, insert into a full list) leave the list as
// it was. The length field gives the entry count after the item, truncated
// to nine bits.

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CMPW   = ((CW > 9) ? CW : 9) + 1;
  localparam int LEVELS = ($clog2(DEPTH) + 1) / 2;
  localparam int CNTW   = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CNTW-1:0] wait_r, wait_nxt;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  out_item_t       out_r, out_nxt;

  logic            accept;
  logic [CMPW-1:0] pos_x, cnt_x, pos_m1;
  logic            in_range, ins_range, full;
  logic [IW-1:0]   op_idx;
  cell_ctrl_t      ctrl;

  data_t [DEPTH-1:0] cell_data;
  data_t [DEPTH-1:0] cell_tap;
  data_t             tree_root;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_READ);

  // Position checks, all in one width wide enough for both count and position.
  assign pos_x     = CMPW'(in_item.position);
  assign cnt_x     = CMPW'(count_r);
  assign pos_m1    = pos_x - CMPW'(1);
  assign in_range  = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_range = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign full      = (cnt_x == CMPW'(DEPTH));
  assign op_idx    = pos_m1[IW-1:0];

  always_comb begin
    ctrl.ins = accept && (in_item.opcode == OP_INSERT) && ins_range && !full;
    ctrl.del = accept && (in_item.opcode == OP_DELETE) && in_range;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    wait_nxt       = wait_r;
    rd_idx_nxt     = rd_idx_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.read_value = '0;
          out_nxt.status     = STAT_OK;
          if (ctrl.ins) begin
            count_nxt = count_r + CW'(1);
          end else if (ctrl.del) begin
            count_nxt = count_r - CW'(1);
          end
          case (in_item.opcode)
            OP_READ: begin
              if (!in_range) begin
                out_nxt.status = STAT_RANGE;
              end
            end
            OP_INSERT: begin
              if (!ins_range) begin
                out_nxt.status = STAT_RANGE;
              end else if (full) begin
                out_nxt.status = STAT_FULL;
              end
            end
            OP_DELETE: begin
              if (!in_range) begin
                out_nxt.status = STAT_RANGE;
              end
            end
            default: begin
              out_nxt.status = STAT_RANGE;
            end
          endcase
          out_nxt.length = 9'(CMPW'(count_nxt));
          if ((in_item.opcode == OP_READ) && in_range) begin
            // The chosen cell's tap must pass through every register level of the tree to reach the root.
            rd_idx_nxt = op_idx;
            wait_nxt   = CNTW'(LEVELS);
            state_nxt  = S_READ;
          end else begin
            out_strobe_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        if (wait_r == '0) begin
          out_nxt.read_value = tree_root;
          out_nxt.status     = STAT_OK;
          out_nxt.length     = 9'(CMPW'(count_r));
          out_strobe_nxt     = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          wait_nxt = wait_r - CNTW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      wait_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      wait_r       <= wait_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    out_r    <= out_nxt;
  end

  // The cell chain. Each cell sees its neighbors; the ends see zero.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    data_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[k+1];
    end

    ple_cell #(
      .IW (IW),
      .K  (k)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .idx    (op_idx),
      .rd_idx (rd_idx_r),
      .value  (in_item.value),
      .left   (left_w),
      .right  (right_w),
      .data   (cell_data[k]),
      .tap    (cell_tap[k])
    );
  end

  ple_read_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk    (clk),
    .leaves (cell_tap),
    .root   (tree_root)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

[design/ple_cell.sv]
`timescale 1ns / 1ps

module ple_cell
  import ple_pkg::*;
#(
  parameter int IW = 8,
  parameter int K  = 0
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [IW-1:0] idx,
  input  logic [IW-1:0] rd_idx,
  input  data_t         value,
  input  data_t         left,
  input  data_t         right,
  output data_t         data,
  output data_t         tap
);

  localparam logic [IW-1:0] KI = IW'(K);

  data_t data_r;

  // Cells at or behind the operation point move; the others hold.
  always_ff @(posedge clk) begin
    if (ctrl.ins && (KI >= idx)) begin
      data_r <= (KI == idx) ? value : left;
    end else if (ctrl.del && (KI >= idx)) begin
      data_r <= right;
    end
  end

  assign data = data_r;
  assign tap  = (KI == rd_idx) ? data_r : '0;

endmodule

[design/ple_read_tree.sv]
`timescale 1ns / 1ps

module ple_read_tree
  import ple_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                   clk,
  input  data_t [DEPTH-1:0]      leaves,
  output data_t                  root
);

  // Radix-4 OR tree, one register per level; only the selected leaf is nonzero.
  localparam int LEVELS = ($clog2(DEPTH) + 1) / 2;
  localparam int NLEAF  = 1 << (2 * LEVELS);
  localparam int NI     = (NLEAF - 1) / 3;

  data_t node_r [NI];
  data_t kid_w  [NI][4];

  for (genvar n = 0; n < NI; n++) begin : g_node
    for (genvar j = 0; j < 4; j++) begin : g_kid
      localparam int C = 4 * n + 1 + j;
      if (C < NI) begin : g_inner
        assign kid_w[n][j] = node_r[C];
      end else if (C - NI < DEPTH) begin : g_leaf
        assign kid_w[n][j] = leaves[C - NI];
      end else begin : g_pad
        assign kid_w[n][j] = '0;
      end
    end

    always_ff @(posedge clk) begin
      node_r[n] <= kid_w[n][0] | kid_w[n][1] | kid_w[n][2] | kid_w[n][3];
    end
  end

  assign root = node_r[0];

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 256;

  // Opcode 3 has no meaning in the block and must be refused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Random stimulus leans toward filling the list, emptying it, or a balanced mix.
  typedef enum {MIX_OPS, GROW_LIST, SHRINK_LIST} op_mix_t;

  // Keeps a mirror of the list and predicts the reply to every accepted command.
  // Replies come back in order, one per command, so a FIFO of expected replies
  // is all the matching needs.
  class list_checker;
    data_t       shadow_list[$];
    out_item_t   expected_replies[$];
    int unsigned failures;
    int unsigned replies_checked;
    int unsigned op_seen[4];
    int unsigned status_seen[4];
    int unsigned peak_length;

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    // Predicts the reply for a command accepted at this clock edge.
    function void note_command(in_item_t cmd);
      out_item_t   reply;
      int unsigned len;
      int unsigned pos;
      len = shadow_list.size();
      pos = cmd.position;
      reply = '0;
      reply.status = STAT_OK;
      op_seen[cmd.opcode]++;
      case (cmd.opcode)
        OP_READ: begin
          if (pos >= 1 && pos <= len) begin
            reply.read_value = shadow_list[pos - 1];
          end else begin
            reply.status = STAT_RANGE;
          end
        end
        OP_INSERT: begin
          // The position check wins over the full check.
          if (pos < 1 || pos > len + 1) begin
            reply.status = STAT_RANGE;
          end else if (len >= LIST_DEPTH) begin
            reply.status = STAT_FULL;
          end else begin
            shadow_list.insert(pos - 1, cmd.value);
          end
        end
        OP_DELETE: begin
          if (pos >= 1 && pos <= len) begin
            shadow_list.delete(pos - 1);
          end else begin
            reply.status = STAT_RANGE;
          end
        end
        default: begin
          reply.status = STAT_RANGE;
        end
      endcase
      reply.length = 9'(shadow_list.size());
      if (shadow_list.size() > peak_length) begin
        peak_length = shadow_list.size();
      end
      expected_replies.push_back(reply);
    endfunction

    // Compares one strobed reply with the oldest prediction.
    function void check_reply(out_item_t got);
      out_item_t want;
      status_seen[got.status]++;
      if (expected_replies.size() == 0) begin
        log_failure($sformatf("unexpected reply: value %0d status %0d length %0d",
                              got.read_value, got.status, got.length));
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.length !== want.length) begin
        log_failure({
          $sformatf("reply mismatch: expected value %0d status %0d length %0d, ",
                    want.read_value, want.status, want.length),
          $sformatf("got value %0d status %0d length %0d",
                    got.read_value, got.status, got.length)});
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  list_checker list_check = new();

  // Percentage of cycles in which the sender holds back before offering an item.
  int unsigned idle_pct;

  // Length the stimulus believes the list has; it steers position choice so
  // that most commands land on legal positions, and it ends the fill and drain.
  int unsigned len_track;

  positional_list_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Monitor. Both the command handshake and the reply strobe are sampled at
  // the rising edge, before the block's registers update, so the values seen
  // here are the ones that were stable during the cycle that just ended.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        list_check.note_command(in_item);
      end
      if (out_strobe) begin
        list_check.check_reply(out_item);
      end
    end
  end

  function automatic in_item_t make_cmd(logic [1:0] op, logic [8:0] pos, data_t val);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.position = pos;
    cmd.value = val;
    return cmd;
  endfunction

  // Follows the length of the list as the stimulus sees it, using the same
  // legality rules the block applies.
  function automatic void track_length(in_item_t cmd);
    if (cmd.opcode == OP_INSERT && cmd.position >= 1 && cmd.position <= len_track + 1 &&
        len_track < LIST_DEPTH) begin
      len_track++;
    end else if (cmd.opcode == OP_DELETE && cmd.position >= 1 &&
                 cmd.position <= len_track) begin
      len_track--;
    end
  endfunction

  // Builds one random command. A small share is pure noise over the whole
  // field range: any opcode, including the unused one, at any position.
  // The rest are well-formed, with positions inside the list and a bias
  // toward the first and last entries, where the shifting has its edges.
  function automatic in_item_t pick_command(op_mix_t mix);
    in_item_t    cmd;
    int unsigned roll;
    int unsigned top;
    int unsigned sel;
    roll = $urandom_range(99);
    cmd.value = $urandom;
    if (roll >= 94) begin
      cmd.opcode = 2'($urandom_range(3));
      cmd.position = 9'($urandom_range(511));
      return cmd;
    end
    case (mix)
      GROW_LIST:   cmd.opcode = (roll < 84) ? OP_INSERT : OP_READ;
      SHRINK_LIST: cmd.opcode = (roll < 84) ? OP_DELETE : OP_READ;
      default:     cmd.opcode = (roll < 31) ? OP_READ : (roll < 62) ? OP_INSERT : OP_DELETE;
    endcase
    top = (cmd.opcode == OP_INSERT) ? len_track + 1 : len_track;
    if (top == 0) begin
      // Nothing to read or delete yet; these end up refused.
      cmd.position = 9'($urandom_range(3));
      return cmd;
    end
    sel = $urandom_range(7);
    if (sel == 0) begin
      cmd.position = 9'd1;
    end else if (sel == 1) begin
      cmd.position = 9'(top);
    end else begin
      cmd.position = 9'($urandom_range(top, 1));
    end
    return cmd;
  endfunction

  // Offers one command and holds it until the block takes it. Idle cycles
  // are inserted first at the current rate. The strobe side needs no
  // driving: the block cannot be held off.
  task automatic send_command(in_item_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= cmd;
    do begin
      @(posedge clk);
    end while (busy);
    track_length(cmd);
  endtask

  // One stretch of random traffic at a given idle rate. With fill_cycle set,
  // the list is also driven all the way to full, probed while full, and
  // then drained back to empty.
  task automatic run_random_phase(int unsigned pct, int unsigned mixed_items, bit fill_cycle);
    idle_pct = pct;
    repeat (mixed_items) send_command(pick_command(MIX_OPS));
    if (fill_cycle) begin
      while (len_track < LIST_DEPTH) send_command(pick_command(GROW_LIST));
      repeat (14) send_command(pick_command(GROW_LIST));
      while (len_track > 0) send_command(pick_command(SHRINK_LIST));
      repeat (6) send_command(pick_command(SHRINK_LIST));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    idle_pct = 0;
    len_track = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. On the empty list every read, delete and misplaced
    // insert must be refused. Then the list is built up with the extreme
    // values at the front, the back and in the middle, read at both ends,
    // just past the back and far beyond it, and taken apart again from the end,
    // the front and the middle.
    send_command(make_cmd(OP_READ,   9'd1,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd0,   32'sd0));
    send_command(make_cmd(OP_DELETE, 9'd1,   32'sd0));
    send_command(make_cmd(OP_INSERT, 9'd2,   32'sd5));
    send_command(make_cmd(OP_INSERT, 9'd0,   32'sd5));
    send_command(make_cmd(OP_UNUSED, 9'd1,   -32'sd1));
    send_command(make_cmd(OP_INSERT, 9'd1,   32'sh7fff_ffff));
    send_command(make_cmd(OP_INSERT, 9'd1,   32'sh8000_0000));
    send_command(make_cmd(OP_INSERT, 9'd3,   -32'sd1));
    send_command(make_cmd(OP_INSERT, 9'd2,   32'sd0));
    send_command(make_cmd(OP_INSERT, 9'd5,   32'sha5a5_5a5a));
    send_command(make_cmd(OP_READ,   9'd1,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd5,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd6,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd511, 32'sd0));
    send_command(make_cmd(OP_INSERT, 9'd511, 32'sd9));
    send_command(make_cmd(OP_DELETE, 9'd6,   32'sd0));
    send_command(make_cmd(OP_DELETE, 9'd511, 32'sd0));
    send_command(make_cmd(OP_DELETE, 9'd5,   32'sd0));
    send_command(make_cmd(OP_DELETE, 9'd1,   32'sd0));
    send_command(make_cmd(OP_DELETE, 9'd2,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd1,   32'sd0));
    send_command(make_cmd(OP_READ,   9'd2,   32'sd0));
    send_command(make_cmd(OP_UNUSED, 9'd511, 32'sd0));

    // Random part: a heavy-idle sender with a full fill and drain of the
    // list, then a sender that idles most of the time, then back to back.
    run_random_phase(38, 100, 1'b1);
    run_random_phase(67, 130, 1'b0);
    run_random_phase(0,  160, 1'b0);

    // Let the last replies drain, then give a read time to finish in case
    // anything stray is still in flight.
    start <= 1'b0;
    while (list_check.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $write("Covered %0d reads, %0d inserts, %0d deletes and %0d unused opcodes; ",
           list_check.op_seen[OP_READ], list_check.op_seen[OP_INSERT],
           list_check.op_seen[OP_DELETE], list_check.op_seen[OP_UNUSED]);
    $display("%0d replies checked.", list_check.replies_checked);
    $display("Statuses seen: %0d ok, %0d out of range, %0d full; peak length %0d; %0d failures.",
             list_check.status_seen[STAT_OK], list_check.status_seen[STAT_RANGE],
             list_check.status_seen[STAT_FULL], list_check.peak_length, list_check.failures);
    if (list_check.failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of about a thousand items.
  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

endmodule
